[design/atrl_pkg.sv]
// shared types and constants of the averaged thermostat relay lockout block
// no dependencies; used by atrl_avg and the top level
`default_nettype none

package atrl_pkg;

    // moving average window, a power of two
    localparam int DEPTH      = 8;
    localparam int DEPTH_LOG2 = $clog2(DEPTH);

    // field widths
    localparam int TEMP_W  = 13;
    localparam int SP_W    = 9;
    localparam int TSS_W   = 16;
    localparam int TSC_W   = 20;
    localparam int SUM_W   = TEMP_W + DEPTH_LOG2;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SET_POINT       = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_LOCKOUT_TIME    = 2'd2;

    // configuration reset values
    localparam logic signed [SP_W-1:0] SP_RESET  = 9'sd65;
    localparam logic [TSS_W-1:0]       SI_RESET  = 16'd2000;
    localparam logic [TSC_W-1:0]       LT_RESET  = 20'd300000;

    // saturation limits of the tick counters
    localparam logic [TSS_W-1:0] TSS_MAX = {TSS_W{1'b1}};
    localparam logic [TSC_W-1:0] TSC_MAX = {TSC_W{1'b1}};

    // result of the averaging stage for one tick
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    taken;
    } t_avg_res;

endpackage

`default_nettype wire

[design/atrl_avg.sv]
// sample ring, running sum and sample interval timing
// depends on atrl_pkg
`default_nettype none

module atrl_avg (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_fire,
    input  wire logic signed [atrl_pkg::TEMP_W-1:0] i_reading,
    input  wire logic [atrl_pkg::TSS_W-1:0]        i_interval,
    output atrl_pkg::t_avg_res                     o_res
);

    logic signed [atrl_pkg::TEMP_W-1:0]   r_ring [atrl_pkg::DEPTH];
    logic [atrl_pkg::DEPTH_LOG2-1:0]      r_pos;
    logic [atrl_pkg::DEPTH_LOG2-1:0]      n_pos;
    logic                                 r_primed;
    logic signed [atrl_pkg::SUM_W-1:0]    r_sum;
    logic signed [atrl_pkg::SUM_W-1:0]    n_sum;
    logic [atrl_pkg::TSS_W-1:0]           r_tss;
    logic [atrl_pkg::TSS_W-1:0]           n_tss;
    logic [atrl_pkg::TSS_W-1:0]           tss_inc;
    logic                                 due;
    logic                                 taken;
    logic signed [atrl_pkg::SUM_W-1:0]    reading_ext;
    logic signed [atrl_pkg::SUM_W-1:0]    oldest_ext;

    // saturating tick count and sample decision
    assign tss_inc = (r_tss == atrl_pkg::TSS_MAX) ? r_tss : r_tss + 1'b1;
    assign due     = (tss_inc >= i_interval);
    assign taken   = !r_primed || due;
    assign n_pos   = r_pos + 1'b1;

    assign reading_ext = atrl_pkg::SUM_W'(i_reading);
    assign oldest_ext  = atrl_pkg::SUM_W'(r_ring[n_pos]);

    // next running sum
    always_comb begin
        n_sum = r_sum;
        n_tss = tss_inc;
        if (!r_primed) begin
            n_sum = reading_ext <<< atrl_pkg::DEPTH_LOG2;
            n_tss = '0;
        end else if (due) begin
            n_sum = r_sum + reading_ext - oldest_ext;
            n_tss = '0;
        end
    end

    // sum first, taken flag in the lowest bit
    assign o_res = {n_sum, taken};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_primed <= 1'b0;
            r_sum    <= '0;
            r_tss    <= '0;
        end else if (i_fire) begin
            r_primed <= 1'b1;
            r_sum    <= n_sum;
            r_tss    <= n_tss;
            if (r_primed && due) begin
                r_pos <= n_pos;
            end
        end
    end

    // ring storage, filled whole by the first tick
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (!r_primed) begin
                for (int i = 0; i < atrl_pkg::DEPTH; i++) begin
                    r_ring[i] <= i_reading;
                end
            end else if (due) begin
                r_ring[n_pos] <= i_reading;
            end
        end
    end

endmodule

`default_nettype wire

[design/averaged_thermostat_relay_lockout.sv]
// Averaged thermostat with heater relay lockout.
// Slave stream: one beat per millisecond tick. i_s_tdata carries temp_sample
// (signed 1/16 degree F) in bits 12:0, i_s_tuser[0] is sample_ok; a reading
// that is not ok counts as zero. Master stream: one result beat per input beat,
// o_m_tdata bits 12:0 hold the floor moving average over 8 samples, o_m_tuser
// holds heat_on, relay_locked and sample_taken from bit 0 up.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 set point,
// 1 sample interval, 2 lockout time) and i_cfg_data; writes to index 3 are
// dropped. o_cfg_ready is always high; write only while the block is idle.
// Path: an accepted beat is registered in the input register, then processed
// into the result register once the result stage can advance and offered on
// the master side from then on. Throughput is one beat per cycle while the
// receiver takes results, as the running sum and tick counters are updated
// once per beat.
// Reset (synchronous, active low) empties both stages, loads the register
// defaults, turns the relay off and allows a relay change at once; the first
// tick after reset fills the whole sample ring. When the receiver stalls the
// result is held and the input register still takes one more beat, after
// which o_s_tready drops until the result is taken.
`default_nettype none

module averaged_thermostat_relay_lockout (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // slave stream
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire [15:0]                          i_s_tdata,   // [12:0] temp_sample
    input  wire [0:0]                           i_s_tuser,   // [0] sample_ok
    // master stream
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [15:0]                         o_m_tdata,   // [12:0] average_temp
    output logic [2:0]                          o_m_tuser,   // [0] heat_on,
                                                             // [1] relay_locked,
                                                             // [2] sample_taken
    // configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [atrl_pkg::CIDX_W-1:0]          i_cfg_index,
    input  wire [atrl_pkg::CFG_W-1:0]           i_cfg_data
);

    // configuration registers
    logic signed [atrl_pkg::SP_W-1:0]    r_set_point;
    logic [atrl_pkg::TSS_W-1:0]          r_interval;
    logic [atrl_pkg::TSC_W-1:0]          r_lockout;

    // input stage
    logic                                r_in_valid;
    logic signed [atrl_pkg::TEMP_W-1:0]  r_in_temp;
    logic                                r_in_ok;

    // relay state
    logic                                r_relay;
    logic                                n_relay;
    logic [atrl_pkg::TSC_W-1:0]          r_tsc;
    logic [atrl_pkg::TSC_W-1:0]          n_tsc;
    logic [atrl_pkg::TSC_W-1:0]          tsc_inc;

    // result stage
    logic                                r_out_valid;
    logic signed [atrl_pkg::TEMP_W-1:0]  r_out_avg;
    logic                                r_out_relay;
    logic                                r_out_locked;
    logic                                r_out_taken;

    logic                                advance;
    logic                                fire;
    logic signed [atrl_pkg::TEMP_W-1:0]  reading;
    logic signed [atrl_pkg::SUM_W-1:0]   sp_scaled;
    logic signed [atrl_pkg::SUM_W-1:0]   avg_full;
    logic                                want;
    logic                                change;
    logic                                allowed;
    logic                                locked;
    atrl_pkg::t_avg_res                  avg_res;

    // handshakes
    assign advance     = !r_out_valid || i_m_tready;
    assign fire        = r_in_valid && advance;
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_point <= atrl_pkg::SP_RESET;
            r_interval  <= atrl_pkg::SI_RESET;
            r_lockout   <= atrl_pkg::LT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                atrl_pkg::CFG_SET_POINT:
                    r_set_point <= i_cfg_data[atrl_pkg::SP_W-1:0];
                atrl_pkg::CFG_SAMPLE_INTERVAL:
                    r_interval <= i_cfg_data[atrl_pkg::TSS_W-1:0];
                atrl_pkg::CFG_LOCKOUT_TIME:
                    r_lockout <= i_cfg_data[atrl_pkg::TSC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_temp <= i_s_tdata[atrl_pkg::TEMP_W-1:0];
            r_in_ok   <= i_s_tuser[0];
        end
    end

    assign reading = r_in_ok ? r_in_temp : '0;

    // ring and running sum
    atrl_avg u_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_reading  (reading),
        .i_interval (r_interval),
        .o_res      (avg_res)
    );

    // relay decision against the exact average
    assign sp_scaled = atrl_pkg::SUM_W'(r_set_point) <<< (4 + atrl_pkg::DEPTH_LOG2);
    assign want      = (sp_scaled > avg_res.sum);
    assign tsc_inc   = (r_tsc == atrl_pkg::TSC_MAX) ? r_tsc : r_tsc + 1'b1;
    assign change    = (want != r_relay);
    assign allowed   = (tsc_inc >= r_lockout);
    assign locked    = change && !allowed;
    assign n_relay   = (change && allowed) ? want : r_relay;
    assign n_tsc     = (change && allowed) ? '0 : tsc_inc;
    assign avg_full  = avg_res.sum >>> atrl_pkg::DEPTH_LOG2;

    // relay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay <= 1'b0;
            r_tsc   <= atrl_pkg::TSC_MAX;
        end else if (fire) begin
            r_relay <= n_relay;
            r_tsc   <= n_tsc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_avg    <= avg_full[atrl_pkg::TEMP_W-1:0];
            r_out_relay  <= n_relay;
            r_out_locked <= locked;
            r_out_taken  <= avg_res.taken;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(16 - atrl_pkg::TEMP_W){1'b0}}, r_out_avg};
    assign o_m_tuser  = {r_out_taken, r_out_locked, r_out_relay};

endmodule

`default_nettype wire

[sim/averaged_thermostat_relay_lockout_tb.sv]
// self-checking testbench for averaged_thermostat_relay_lockout: drives ticks,
// tracks the moving average and relay lockout on its own and checks every beat
// depends on atrl_pkg and the averaged_thermostat_relay_lockout top level only

module averaged_thermostat_relay_lockout_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int LONG_HOLD      = 64;
    localparam int TEMP_MIN       = -4096;
    localparam int TEMP_MAX       = 4095;

    // index with no register behind it, writes are dropped
    localparam logic [atrl_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;

    // one result beat as the block should present it
    typedef struct packed {
        logic                        heat_on;
        logic                        relay_locked;
        logic [atrl_pkg::TEMP_W-1:0] average;
        logic                        sample_taken;
    } t_tick_result;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        s_tvalid;
    wire                         s_tready;
    logic [15:0]                 s_tdata;     // [12:0] temp_sample
    logic [0:0]                  s_tuser;     // [0] sample_ok
    wire                         m_tvalid;
    logic                        m_tready;
    wire  [15:0]                 m_tdata;     // [12:0] average_temp
    wire  [2:0]                  m_tuser;     // [0] heat_on, [1] relay_locked,
                                              // [2] sample_taken
    logic                        cfg_valid;
    wire                         cfg_ready;
    logic [atrl_pkg::CIDX_W-1:0] cfg_index;
    logic [atrl_pkg::CFG_W-1:0]  cfg_data;

    // thermostat state as tracked by the testbench
    int                               ring [atrl_pkg::DEPTH];
    int                               ring_pos;
    logic                             primed;
    int                               ring_sum;
    logic [atrl_pkg::TSS_W-1:0]       since_sample;
    logic [atrl_pkg::TSC_W-1:0]       since_change;
    logic                             relay;
    logic signed [atrl_pkg::SP_W-1:0] set_point_q;
    logic [atrl_pkg::TSS_W-1:0]       interval_q;
    logic [atrl_pkg::TSC_W-1:0]       lockout_q;
    t_tick_result                     tick_results [$];

    // run control and bookkeeping
    logic idle_en       = 1'b0;
    logic long_hold_req = 1'b0;
    int   hold_left     = 0;
    int   stall_left    = 0;
    int   quiet_cycles  = 0;
    int   mismatches    = 0;
    int   reported      = 0;
    int   result_beats  = 0;

    averaged_thermostat_relay_lockout u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // one tick: sample ring update, relay decision with lockout
    function automatic t_tick_result thermostat_tick(input int reading);
        t_tick_result res;
        logic         want;
        res = '0;
        if (!primed) begin
            // first tick fills the whole ring
            for (int i = 0; i < atrl_pkg::DEPTH; i++) ring[i] = reading;
            ring_sum     = reading * atrl_pkg::DEPTH;
            ring_pos     = 0;
            since_sample = '0;
            primed       = 1'b1;
            res.sample_taken = 1'b1;
        end else begin
            if (since_sample != atrl_pkg::TSS_MAX) since_sample++;
            if (since_sample >= interval_q) begin
                ring_pos       = (ring_pos + 1) % atrl_pkg::DEPTH;
                ring_sum       = ring_sum + reading - ring[ring_pos];
                ring[ring_pos] = reading;
                since_sample   = '0;
                res.sample_taken = 1'b1;
            end
        end
        if (since_change != atrl_pkg::TSC_MAX) since_change++;
        // set point in whole degrees against the exact sum
        want = (int'(set_point_q) * 16 * atrl_pkg::DEPTH) > ring_sum;
        if (want != relay) begin
            if (since_change >= lockout_q) begin
                relay        = want;
                since_change = '0;
            end else begin
                res.relay_locked = 1'b1;
            end
        end
        res.heat_on = relay;
        res.average = atrl_pkg::TEMP_W'(ring_sum >>> atrl_pkg::DEPTH_LOG2);
        return res;
    endfunction

    // reading near a center, clamped to the sensor range
    function automatic int near_temp(input int center, input int spread);
        int t;
        t = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (t > TEMP_MAX) t = TEMP_MAX;
        else if (t < TEMP_MIN) t = TEMP_MIN;
        return t;
    endfunction

    // offer one tick beat, starts and ends at a falling edge
    task automatic send_tick(input int temp, input logic ok);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, atrl_pkg::TEMP_W'(temp)};
        s_tuser  = ok;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tick_results.push_back(thermostat_tick(ok ? temp : 0));
        @(negedge clk);
    endtask

    // register write once all pending results are out
    task automatic write_reg(input logic [atrl_pkg::CIDX_W-1:0] idx,
                             input logic [atrl_pkg::CFG_W-1:0] value);
        s_tvalid = 1'b0;
        while (tick_results.size() != 0) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            atrl_pkg::CFG_SET_POINT:
                set_point_q = value[atrl_pkg::SP_W-1:0];
            atrl_pkg::CFG_SAMPLE_INTERVAL:
                interval_q  = value[atrl_pkg::TSS_W-1:0];
            atrl_pkg::CFG_LOCKOUT_TIME:
                lockout_q   = value[atrl_pkg::TSC_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // reset defaults: first tick fills the ring, relay may switch at once
    task automatic test_reset_defaults();
        send_tick(0, 1'b1);
        send_tick(TEMP_MAX, 1'b1);
        send_tick(-1, 1'b0);
    endtask

    // field and register extremes, invalid readings, lockout blocking
    task automatic test_directed_extremes();
        write_reg(atrl_pkg::CFG_SAMPLE_INTERVAL, atrl_pkg::CFG_W'(1));
        write_reg(atrl_pkg::CFG_LOCKOUT_TIME, atrl_pkg::CFG_W'(0));
        write_reg(atrl_pkg::CFG_SET_POINT, atrl_pkg::CFG_W'(200));
        repeat (8) send_tick(TEMP_MAX, 1'b1);
        // sample every tick, lockout never expires after a change
        write_reg(atrl_pkg::CFG_SET_POINT, atrl_pkg::CFG_W'(-40));
        write_reg(atrl_pkg::CFG_SAMPLE_INTERVAL, atrl_pkg::CFG_W'(0));
        write_reg(atrl_pkg::CFG_LOCKOUT_TIME, atrl_pkg::CFG_W'(atrl_pkg::TSC_MAX));
        repeat (5) send_tick(TEMP_MIN, 1'b1);
        repeat (2) send_tick(TEMP_MAX, 1'b0);
        // dropped write, junk above the set point field
        write_reg(CFG_UNUSED, {atrl_pkg::CFG_W{1'b1}});
        write_reg(atrl_pkg::CFG_SET_POINT, {11'h5A5, 9'd255});
        write_reg(atrl_pkg::CFG_LOCKOUT_TIME, atrl_pkg::CFG_W'(0));
        repeat (2) send_tick(-1, 1'b1);
        write_reg(atrl_pkg::CFG_SET_POINT, {11'h2AA, 9'h100});
        write_reg(atrl_pkg::CFG_SAMPLE_INTERVAL, atrl_pkg::CFG_W'(atrl_pkg::TSS_MAX));
        repeat (2) send_tick(1234, 1'b1);
    endtask

    // random settings per phase, readings wander around the set point
    task automatic test_random_phases(input int phase_count, input int items_each,
                                      input logic allow_idle);
        logic signed [atrl_pkg::SP_W-1:0] sp;
        logic [atrl_pkg::TSS_W-1:0]       iv;
        logic [atrl_pkg::TSC_W-1:0]       lk;
        int                               drift;
        int                               pick;
        for (int p = 0; p < phase_count; p++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       sp = atrl_pkg::SP_W'(-40);
                1:       sp = atrl_pkg::SP_W'(200);
                2:       sp = atrl_pkg::SP_W'(-256);
                3:       sp = atrl_pkg::SP_W'(255);
                default: sp = atrl_pkg::SP_W'(int'($urandom_range(0, 240)) - 40);
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       iv = '0;
                1:       iv = atrl_pkg::TSS_MAX;
                2, 3:    iv = atrl_pkg::TSS_W'($urandom_range(1, 300));
                default: iv = atrl_pkg::TSS_W'($urandom_range(1, 4));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       lk = '0;
                1:       lk = atrl_pkg::TSC_MAX;
                2:       lk = atrl_pkg::TSC_W'($urandom_range(0, 2000));
                default: lk = atrl_pkg::TSC_W'($urandom_range(0, 40));
            endcase
            write_reg(atrl_pkg::CFG_SET_POINT,
                      {(atrl_pkg::CFG_W - atrl_pkg::SP_W)'($urandom), sp});
            write_reg(atrl_pkg::CFG_SAMPLE_INTERVAL,
                      {(atrl_pkg::CFG_W - atrl_pkg::TSS_W)'($urandom), iv});
            write_reg(atrl_pkg::CFG_LOCKOUT_TIME, lk);
            idle_en = allow_idle ? ($urandom_range(0, 3) != 0) : 1'b0;
            drift = 0;
            for (int n = 0; n < items_each; n++) begin
                pick  = $urandom_range(0, 19);
                drift = drift + int'($urandom_range(0, 48)) - 24;
                if (drift > 600) drift = 600;
                else if (drift < -600) drift = -600;
                if (pick == 0)
                    send_tick(int'($urandom_range(0, 8191)) - 4096, 1'b1);
                else if (pick == 1)
                    send_tick(int'($urandom_range(0, 8191)) - 4096, 1'b0);
                else if (pick == 2)
                    send_tick($urandom_range(0, 1) ? TEMP_MAX : TEMP_MIN, 1'b1);
                else
                    send_tick(near_temp(int'(sp) * 16 + drift, 40), 1'b1);
            end
        end
    endtask

    // receiver holds off for a long stretch while ticks keep coming
    task automatic test_backpressure();
        write_reg(atrl_pkg::CFG_SAMPLE_INTERVAL, atrl_pkg::CFG_W'(1));
        write_reg(atrl_pkg::CFG_LOCKOUT_TIME, atrl_pkg::CFG_W'(3));
        write_reg(atrl_pkg::CFG_SET_POINT, atrl_pkg::CFG_W'(70));
        idle_en = 1'b0;
        for (int k = 0; k < 3; k++) begin
            long_hold_req = 1'b1;
            for (int n = 0; n < 40; n++) send_tick(near_temp(70 * 16, 300), 1'b1);
        end
    endtask

    // receiver ready: random stall bursts, long hold on request
    always @(negedge clk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
        end else begin
            m_tready = 1'b1;
        end
    end

    // result check against the oldest pending tick
    always @(posedge clk) begin : check_beat
        t_tick_result exp_res;
        if (rst_n && m_tvalid && m_tready) begin
            if (tick_results.size() == 0) begin
                mismatches++;
                if (reported < MAX_REPORTS)
                    $display("beat %0d: result with no tick pending", result_beats);
                reported++;
            end else begin
                exp_res = tick_results.pop_front();
                if (m_tuser[0] !== exp_res.heat_on ||
                    m_tuser[1] !== exp_res.relay_locked ||
                    m_tdata[atrl_pkg::TEMP_W-1:0] !== exp_res.average ||
                    m_tuser[2] !== exp_res.sample_taken) begin
                    mismatches++;
                    if (reported < MAX_REPORTS)
                        $display({"beat %0d: exp on/lock/avg/smp %0b/%0b/%0d/%0b",
                                  " got %0b/%0b/%0d/%0b"},
                                 result_beats, exp_res.heat_on, exp_res.relay_locked,
                                 $signed(exp_res.average), exp_res.sample_taken,
                                 m_tuser[0], m_tuser[1],
                                 $signed(m_tdata[atrl_pkg::TEMP_W-1:0]), m_tuser[2]);
                    reported++;
                end
            end
            result_beats++;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = atrl_pkg::CFG_SET_POINT;
        cfg_data  = '0;
        for (int i = 0; i < atrl_pkg::DEPTH; i++) ring[i] = 0;
        ring_pos     = 0;
        primed       = 1'b0;
        ring_sum     = 0;
        since_sample = '0;
        since_change = atrl_pkg::TSC_MAX;
        relay        = 1'b0;
        set_point_q  = atrl_pkg::SP_RESET;
        interval_q   = atrl_pkg::SI_RESET;
        lockout_q    = atrl_pkg::LT_RESET;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_extremes();
        test_random_phases(14, 100, 1'b1);
        test_backpressure();
        test_random_phases(2, 80, 1'b0);

        // let every pending result drain
        s_tvalid = 1'b0;
        while (tick_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
design/atrl_pkg.sv
design/atrl_avg.sv
design/averaged_thermostat_relay_lockout.sv
sim/averaged_thermostat_relay_lockout_tb.sv
